// ===== src/assert_macros.svh =====
// Assertion macros shared by the SD SPI frame and CRC engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define SDC_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a cause is followed by an effect in the next cycle.
`define SDC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// Checks that a cause implies an effect in the same cycle.
`define SDC_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

// ===== src/sdcrc_pkg.sv =====
// Types, constants and CRC helpers for the SD SPI frame and CRC engine.
package sdcrc_pkg;

  localparam logic       CMD_FRAME   = 1'b0;
  localparam logic       CMD_DATA    = 1'b1;
  localparam logic [5:0] STOP_INDEX  = 6'd12;
  localparam logic [7:0] FRAME_START = 8'h40;
  localparam logic [7:0] FILL_BYTE   = 8'hFF;
  localparam logic [6:0] CRC7_POLY   = 7'h09;
  localparam logic [15:0] CRC16_POLY = 16'h1021;
  localparam int         MSG_BITS    = 40;
  localparam int         FRAME_BYTES = 6;

  typedef struct packed {
    logic        command;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [7:0]  data_byte;
    logic        last_byte;
  } sdcrc_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] crc_value;
    logic        crc_zero;
    logic        last_of_run;
  } sdcrc_out_t;

  typedef logic [MSG_BITS-1:0][6:0] crc7_cols_t;

  // CRC7 with a zero seed is linear in the message, so each message bit
  // contributes a fixed pattern. Column j belongs to the j-th bit sent.
  function automatic crc7_cols_t crc7_columns();
    crc7_cols_t cols;
    logic [6:0] c;
    logic       fb;
    for (int j = 0; j < MSG_BITS; j++) begin
      c = '0;
      for (int k = 0; k < MSG_BITS; k++) begin
        fb = c[6] ^ (k == j);
        c  = {c[5:0], 1'b0};
        if (fb) begin
          c = c ^ CRC7_POLY;
        end
      end
      cols[j] = c;
    end
    return cols;
  endfunction

  localparam crc7_cols_t CRC7_COLS = crc7_columns();

  // One byte of CRC-16 XMODEM, most significant bit first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC16_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/sd_spi_frame_crc_engine.sv =====
// SD SPI command framing with CRC7 and a running CRC-16 over data bytes.
// A request passes the input register, then the result register shows its first result.
// Data bytes go one per cycle unless the output stalls; a command frame holds the output
// for 6 bytes (7 for stop transmission), one per cycle while out_ready is high, as the
// next request waits. Non-final data bytes give no result and never wait on the output.
// Synchronous active-high reset empties both registers and clears the CRC-16 accumulator.
`include "assert_macros.svh"

module sd_spi_frame_crc_engine
  import sdcrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  sdcrc_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output sdcrc_out_t out_data
);

  // Input register.
  logic      s1_valid;
  sdcrc_in_t s1;

  // Result register.
  logic                  s2_valid;
  logic                  s2_kind;
  logic [FRAME_BYTES-1:0][7:0] s2_bytes;
  logic                  s2_stop;
  logic [15:0]           s2_crc;
  logic [2:0]            s2_cnt;

  logic [15:0] acc;

  logic                  s1_nores;
  logic                  s2_last;
  logic                  s2_free;
  logic                  s1_fire;
  logic [MSG_BITS-1:0]   msg;
  logic [6:0]            crc7;
  logic [15:0]           crc16_next;
  logic [FRAME_BYTES-1:0][7:0] frame_bytes;

  assign s1_nores = (s1.command == CMD_DATA) && !s1.last_byte;
  assign s2_last  = (s2_kind == CMD_DATA) || (s2_cnt == (s2_stop ? 3'd6 : 3'd5));
  assign s2_free  = !s2_valid || (out_ready && s2_last);
  assign s1_fire  = s1_valid && (s1_nores || s2_free);
  assign in_ready = !s1_valid || s1_fire;

  assign msg = {FRAME_START | {2'b00, s1.cmd_index}, s1.argument};

  always_comb begin
    crc7 = '0;
    for (int i = 0; i < MSG_BITS; i++) begin
      if (msg[MSG_BITS-1-i]) begin
        crc7 = crc7 ^ CRC7_COLS[i];
      end
    end
  end

  assign frame_bytes[0] = msg[39:32];
  assign frame_bytes[1] = msg[31:24];
  assign frame_bytes[2] = msg[23:16];
  assign frame_bytes[3] = msg[15:8];
  assign frame_bytes[4] = msg[7:0];
  assign frame_bytes[5] = {crc7, 1'b1};

  assign crc16_next = crc16_byte(acc, s1.data_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1 <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s1_fire && (s1.command == CMD_DATA)) begin
      acc <= s1.last_byte ? 16'h0000 : crc16_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_cnt   <= '0;
    end else if (s2_free) begin
      s2_valid <= s1_fire && !s1_nores;
      s2_cnt   <= '0;
    end else if (out_ready) begin
      s2_cnt <= s2_cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_fire && !s1_nores) begin
      s2_kind  <= s1.command;
      s2_bytes <= frame_bytes;
      s2_stop  <= (s1.cmd_index == STOP_INDEX);
      s2_crc   <= crc16_next;
    end
  end

  always_comb begin
    out_data = '0;
    if (s2_kind == CMD_DATA) begin
      out_data.crc_value = s2_crc;
      out_data.crc_zero  = (s2_crc == 16'h0000);
    end else if (s2_cnt == 3'd6) begin
      out_data.out_byte = FILL_BYTE;
    end else begin
      out_data.out_byte = s2_bytes[s2_cnt];
    end
    out_data.last_of_run = s2_last;
  end

  assign out_valid = s2_valid;

  `SDC_ASSERT_NOW(a_cnt_range, !s2_valid || (s2_cnt != 3'd7 && (s2_stop || s2_cnt != 3'd6)), "frame byte count overran the frame")
  `SDC_ASSERT_IMPL(a_data_single, s2_valid && s2_kind == CMD_DATA, s2_cnt == 3'd0, "data result shown past its first beat")
  `SDC_ASSERT_NEXT(a_acc_clear, s1_fire && s1.command == CMD_DATA && s1.last_byte, acc == 16'h0000, "accumulator not cleared after final data byte")
  `SDC_ASSERT_IMPL(a_no_drop, s1_valid && !s1_nores && !s2_free, !in_ready, "input register overwritten while its result waits")

endmodule
